// File: hw/rtl/cbc_pkg.sv
// ============================================================================
// Cartridge bank controller package
// Shared types, codes and constants for the cartridge bank controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

    // Number of physical ROM address bits that can be reached.
    localparam int ROM_ADDR_BITS = 23;

    // First ROM offset that lies beyond the addressable ROM space.
    localparam logic [23:0] ROM_LIMIT = 24'(2 ** ROM_ADDR_BITS);

    // Reset values of the configuration registers.
    localparam logic [7:0]  MAPPER_CODE_RST = 8'h00;
    localparam logic [23:0] ROM_EXTENT_RST  = 24'h008000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAPPER_CODE = 2'd0;
    localparam logic [1:0] CFG_ROM_EXTENT  = 2'd1;
    localparam logic [1:0] CFG_RAM_PRESENT = 2'd2;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Where an access lands.
    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ROM_READ  = 3'd1,
        TGT_RAM_READ  = 3'd2,
        TGT_RAM_WRITE = 3'd3,
        TGT_READ_FF   = 3'd4,
        TGT_READ_00   = 3'd5,
        TGT_REG_WRITE = 3'd6
    } target_t;

    typedef struct packed {
        logic [7:0]  mapper_code;
        logic [23:0] rom_extent;
        logic        ram_present;
    } cfg_t;

    typedef struct packed {
        logic       ram_enable;
        logic [7:0] low_rom_bank;
        logic [3:0] upper_bank;
        logic       rom_bank_bit_eight;
        logic       advanced_mode;
    } bank_state_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } item_t;

    typedef struct packed {
        target_t     target;
        logic [22:0] rom_address;
        logic [16:0] ram_address;
        logic [7:0]  ram_data;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/cartridge_bank_controller.sv
// ============================================================================
// Cartridge bank controller
// Maps CPU bus accesses onto cartridge ROM and RAM under bank register rules.
// ============================================================================
// Usage:
// Each item on the slave stream is one CPU bus access: s_tuser carries the
// access kind (0 read, 1 write) and s_tdata the address and the write byte.
// Each accepted item produces exactly one item on the master stream that
// says where the access lands (m_tuser) and gives the physical ROM address,
// RAM address and RAM byte (m_tdata). Writes below 0x8000 update the bank
// registers; the next item already sees the new values.
// The configuration channel writes the cartridge type, the ROM size and the
// RAM presence flag; it is always ready and should be used only while no
// item is in flight.
// The item is captured in an input register on acceptance, mapped by short
// logic and captured in the result register, which presents it. One item is
// accepted in every cycle while the receiver takes results.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops until the result is taken.
// Reset clears both pipeline stages, returns the bank registers to bank 1
// with RAM disabled, and restores the configuration to type 0 with 32 KiB
// of ROM and no RAM.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Bus access stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_byte
    input  wire logic [0:0]  s_tuser,   // [0] opcode

    // Mapped access stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [22:0] rom_address, [39:23] ram_address,
                                        // [47:40] ram_data
    output logic [2:0]       m_tuser,   // [2:0] target

    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    cbc_pkg::cfg_t        cfg_reg;
    cbc_pkg::bank_state_t state_reg;
    cbc_pkg::bank_state_t state_next;
    cbc_pkg::item_t       item_reg;
    cbc_pkg::result_t     result_reg;
    cbc_pkg::result_t     result_next;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 s_accept;

    // The input stage moves into the result stage whenever the result stage
    // is empty or is being drained in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.target;
    assign m_tdata  = {result_reg.ram_data, result_reg.ram_address, result_reg.rom_address};

    cbc_map u_map (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    // Configuration registers. Indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.mapper_code <= cbc_pkg::MAPPER_CODE_RST;
            cfg_reg.rom_extent  <= cbc_pkg::ROM_EXTENT_RST;
            cfg_reg.ram_present <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cbc_pkg::CFG_MAPPER_CODE: cfg_reg.mapper_code <= cfg_data[7:0];
                cbc_pkg::CFG_ROM_EXTENT:  cfg_reg.rom_extent  <= cfg_data;
                cbc_pkg::CFG_RAM_PRESENT: cfg_reg.ram_present <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Bank registers change only as an item passes through the mapper.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.ram_enable         <= 1'b0;
            state_reg.low_rom_bank       <= 8'd1;
            state_reg.upper_bank         <= 4'd0;
            state_reg.rom_bank_bit_eight <= 1'b0;
            state_reg.advanced_mode      <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            item_reg.opcode      <= s_tuser[0];
            item_reg.bus_address <= s_tdata[15:0];
            item_reg.write_byte  <= s_tdata[23:16];
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // A stalled input item must still be waiting in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item dropped while stalled");

    // Bank registers move only when an item is mapped.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("bank registers changed without an item");

    // Only ROM reads carry a ROM address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.target != cbc_pkg::TGT_ROM_READ)
            |-> (result_reg.rom_address == 23'd0))
        else $error("ROM address on a non-ROM result");

    // Only RAM writes carry a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.target != cbc_pkg::TGT_RAM_WRITE)
            |-> (result_reg.ram_data == 8'd0))
        else $error("RAM data on a result that is not a RAM write");

endmodule

`default_nettype wire

// File: hw/rtl/cbc_map.sv
// ============================================================================
// Cartridge bank mapper
// Maps one bus access to a ROM or RAM address and computes the next
// banking register values.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cbc_map (
    input  cbc_pkg::item_t       item,
    input  cbc_pkg::cfg_t        cfg,
    input  cbc_pkg::bank_state_t state,
    output cbc_pkg::result_t     result,
    output cbc_pkg::bank_state_t state_next
);

    logic        kind_one;
    logic        kind_one_banked;
    logic        kind_three;
    logic        kind_five;
    logic [15:0] addr;
    logic [7:0]  v;
    logic [8:0]  rom_bank;
    logic [22:0] rom_off;
    logic [3:0]  ram_bank;
    logic [16:0] ram_off;
    logic [7:0]  bank_masked;

    assign addr = item.bus_address;
    assign v    = item.write_byte;

    always_comb
    begin
        kind_one        = cfg.mapper_code inside {[8'h00 : 8'h03]};
        kind_one_banked = cfg.mapper_code inside {[8'h01 : 8'h03]};
        kind_three      = cfg.mapper_code inside {[8'h0F : 8'h13]};
        kind_five       = cfg.mapper_code inside {[8'h19 : 8'h1E]};
    end

    // ROM offset: the bank sits above the 14-bit offset within a 16 KiB bank.
    always_comb
    begin
        if (!addr[14]) begin
            rom_bank = (state.advanced_mode && kind_one) ? {state.upper_bank, 5'b0} : 9'd0;
        end else if (kind_one) begin
            rom_bank = {1'b0, state.low_rom_bank} | {state.upper_bank, 5'b0};
        end else if (kind_five) begin
            rom_bank = {state.rom_bank_bit_eight, state.low_rom_bank};
        end else begin
            rom_bank = {1'b0, state.low_rom_bank};
        end
        rom_off = {rom_bank, addr[13:0]};
    end

    // RAM offset: an 8 KiB bank; simple mode on banked first-kind types pins it to zero.
    always_comb
    begin
        ram_bank = (kind_one_banked && !state.advanced_mode) ? 4'd0 : state.upper_bank;
        ram_off  = {ram_bank, addr[12:0]};
    end

    always_comb
    begin
        result             = '0;
        result.target      = cbc_pkg::TGT_NONE;
        state_next         = state;
        bank_masked        = 8'd0;

        if (item.opcode == cbc_pkg::OP_READ) begin
            if (!addr[15]) begin
                if (({1'b0, rom_off} < cfg.rom_extent) &&
                    ({1'b0, rom_off} < cbc_pkg::ROM_LIMIT)) begin
                    result.target      = cbc_pkg::TGT_ROM_READ;
                    result.rom_address = rom_off;
                end else begin
                    result.target = cbc_pkg::TGT_READ_FF;
                end
            end else if (addr[15:13] == 3'b101) begin
                if (!state.ram_enable) begin
                    result.target = cbc_pkg::TGT_READ_FF;
                end else if (kind_three && state.upper_bank[3]) begin
                    // Clock register selected instead of a RAM bank.
                    result.target = cbc_pkg::TGT_READ_00;
                end else if (cfg.ram_present) begin
                    result.target      = cbc_pkg::TGT_RAM_READ;
                    result.ram_address = ram_off;
                end else begin
                    result.target = cbc_pkg::TGT_READ_FF;
                end
            end
        end else begin
            if (!addr[15]) begin
                result.target = cbc_pkg::TGT_REG_WRITE;
                case (addr[14:13])
                    2'b00:
                    begin
                        state_next.ram_enable = (v[3:0] == 4'hA);
                    end
                    2'b01:
                    begin
                        if (kind_one) begin
                            bank_masked = {3'b0, v[4:0]};
                            state_next.low_rom_bank = (bank_masked == 8'd0) ? 8'd1 : bank_masked;
                        end else if (kind_three) begin
                            bank_masked = {1'b0, v[6:0]};
                            state_next.low_rom_bank = (bank_masked == 8'd0) ? 8'd1 : bank_masked;
                        end else if (kind_five) begin
                            if (!addr[12]) begin
                                state_next.low_rom_bank = v;
                            end else begin
                                state_next.rom_bank_bit_eight = v[0];
                            end
                        end
                    end
                    2'b10:
                    begin
                        if (kind_one) begin
                            state_next.upper_bank = {2'b0, v[1:0]};
                        end else if (kind_three || kind_five) begin
                            state_next.upper_bank = v[3:0];
                        end
                    end
                    default:
                    begin
                        if (kind_one) begin
                            state_next.advanced_mode = v[0];
                        end
                    end
                endcase
            end else if (addr[15:13] == 3'b101) begin
                if (state.ram_enable && cfg.ram_present) begin
                    result.target      = cbc_pkg::TGT_RAM_WRITE;
                    result.ram_address = ram_off;
                    result.ram_data    = v;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/cbc_tb_pkg.sv
// ============================================================================
// Cartridge bank controller bench package
// Bank register tracker that predicts and checks the mapping of each access.
// ============================================================================
`timescale 1ns / 1ps

package cbc_tb_pkg;

    import cbc_pkg::*;

    // Cartridge type ranges of the three mapper kinds.
    localparam logic [7:0] MBC1_BANKED_FIRST = 8'h01;
    localparam logic [7:0] MBC1_LAST         = 8'h03;
    localparam logic [7:0] MBC3_FIRST        = 8'h0F;
    localparam logic [7:0] MBC3_LAST         = 8'h13;
    localparam logic [7:0] MBC5_FIRST        = 8'h19;
    localparam logic [7:0] MBC5_LAST         = 8'h1E;

    // Bus map.
    localparam logic [15:0] BANK_SELECT_BASE = 16'h2000;
    localparam logic [15:0] HIGH_BIT_BASE    = 16'h3000;
    localparam logic [15:0] ROM_SWITCH_BASE  = 16'h4000;
    localparam logic [15:0] MODE_SELECT_BASE = 16'h6000;
    localparam logic [15:0] ROM_WINDOW_END   = 16'h8000;
    localparam logic [15:0] RAM_WINDOW_BASE  = 16'hA000;
    localparam logic [15:0] RAM_WINDOW_END   = 16'hC000;

    localparam int unsigned ROM_BANK_BYTES = 32'h4000;
    localparam int unsigned RAM_BANK_BYTES = 32'h2000;
    localparam logic [3:0]  RAM_ENABLE_KEY = 4'hA;
    localparam logic [3:0]  CLOCK_SELECT_FIRST = 4'h8;

    class bank_map_checker;
        logic [7:0]  cart_type;
        logic [23:0] rom_extent;
        logic        ram_fitted;
        logic        ram_en;
        logic [7:0]  low_bank;
        logic [3:0]  upper_bank;
        logic        bank_bit8;
        logic        adv_mode;
        result_t     expected_maps[$];
        int unsigned mismatches;
        int unsigned accesses;
        int unsigned target_hits[7];

        function new();
            cart_type  = MAPPER_CODE_RST;
            rom_extent = ROM_EXTENT_RST;
            ram_fitted = 1'b0;
            ram_en     = 1'b0;
            low_bank   = 8'd1;
            upper_bank = 4'd0;
            bank_bit8  = 1'b0;
            adv_mode   = 1'b0;
            mismatches = 0;
            accesses   = 0;
            foreach (target_hits[i]) target_hits[i] = 0;
        endfunction

        function bit is_mbc1();
            return cart_type <= MBC1_LAST;
        endfunction

        function bit is_mbc3();
            return cart_type >= MBC3_FIRST && cart_type <= MBC3_LAST;
        endfunction

        function bit is_mbc5();
            return cart_type >= MBC5_FIRST && cart_type <= MBC5_LAST;
        endfunction

        function int pending();
            return expected_maps.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [23:0] value);
            case (idx)
                CFG_MAPPER_CODE: cart_type  = value[7:0];
                CFG_ROM_EXTENT:  rom_extent = value;
                CFG_RAM_PRESENT: ram_fitted = value[0];
                default: ;
            endcase
        endfunction

        // Banked MBC1 types in simple mode always see RAM bank 0; all
        // other types use the upper bank register directly.
        function logic [16:0] ram_byte_address(logic [15:0] addr);
            int unsigned bank;
            int unsigned off;
            bank = 32'(upper_bank);
            if (cart_type >= MBC1_BANKED_FIRST && cart_type <= MBC1_LAST && !adv_mode)
                bank = 0;
            off = bank * RAM_BANK_BYTES + 32'(addr - RAM_WINDOW_BASE);
            return off[16:0];
        endfunction

        // Works out where one accepted access lands and applies any
        // register update it makes.
        function void note_access(logic op, logic [15:0] addr, logic [7:0] wb);
            result_t     r;
            int unsigned bank;
            int unsigned off;
            r.target      = TGT_NONE;
            r.rom_address = '0;
            r.ram_address = '0;
            r.ram_data    = '0;
            accesses++;
            if (op == OP_READ) begin
                if (addr < ROM_WINDOW_END) begin
                    if (addr < ROM_SWITCH_BASE) begin
                        bank = (adv_mode && is_mbc1()) ? (32'(upper_bank) << 5) : 32'd0;
                        off  = bank * ROM_BANK_BYTES + 32'(addr);
                    end
                    else begin
                        bank = 32'(low_bank);
                        if (is_mbc1())
                            bank = bank | (32'(upper_bank) << 5);
                        else if (is_mbc5())
                            bank = bank | (32'(bank_bit8) << 8);
                        off = bank * ROM_BANK_BYTES + 32'(addr - ROM_SWITCH_BASE);
                    end
                    if (off < 32'(rom_extent) && off < 32'(ROM_LIMIT)) begin
                        r.target      = TGT_ROM_READ;
                        r.rom_address = off[22:0];
                    end
                    else begin
                        r.target = TGT_READ_FF;
                    end
                end
                else if (addr >= RAM_WINDOW_BASE && addr < RAM_WINDOW_END) begin
                    if (!ram_en)
                        r.target = TGT_READ_FF;
                    else if (is_mbc3() && upper_bank >= CLOCK_SELECT_FIRST)
                        r.target = TGT_READ_00;
                    else if (ram_fitted) begin
                        r.target      = TGT_RAM_READ;
                        r.ram_address = ram_byte_address(addr);
                    end
                    else
                        r.target = TGT_READ_FF;
                end
            end
            else if (addr < ROM_WINDOW_END) begin
                r.target = TGT_REG_WRITE;
                if (addr < BANK_SELECT_BASE) begin
                    ram_en = (wb[3:0] == RAM_ENABLE_KEY);
                end
                else if (addr < ROM_SWITCH_BASE) begin
                    if (is_mbc1()) begin
                        low_bank = {3'b000, wb[4:0]};
                        if (low_bank == 8'd0) low_bank = 8'd1;
                    end
                    else if (is_mbc3()) begin
                        low_bank = {1'b0, wb[6:0]};
                        if (low_bank == 8'd0) low_bank = 8'd1;
                    end
                    else if (is_mbc5()) begin
                        if (addr < HIGH_BIT_BASE) low_bank = wb;
                        else bank_bit8 = wb[0];
                    end
                end
                else if (addr < MODE_SELECT_BASE) begin
                    if (is_mbc1()) upper_bank = {2'b00, wb[1:0]};
                    else if (is_mbc3() || is_mbc5()) upper_bank = wb[3:0];
                end
                else if (is_mbc1()) begin
                    adv_mode = wb[0];
                end
            end
            else if (addr >= RAM_WINDOW_BASE && addr < RAM_WINDOW_END) begin
                if (ram_en && ram_fitted) begin
                    r.target      = TGT_RAM_WRITE;
                    r.ram_address = ram_byte_address(addr);
                    r.ram_data    = wb;
                end
            end
            expected_maps.push_back(r);
        endfunction

        function void check_mapping(logic [2:0] tgt, logic [47:0] payload);
            result_t want;
            if (expected_maps.size() == 0) begin
                $error("Result with no access outstanding: target %0d", tgt);
                mismatches++;
                return;
            end
            want = expected_maps.pop_front();
            target_hits[want.target]++;
            if (tgt != want.target) begin
                $error("target: expected %0d, got %0d", want.target, tgt);
                mismatches++;
            end
            if (payload[22:0] != want.rom_address) begin
                $error("rom_address: expected 0x%06h, got 0x%06h",
                       want.rom_address, payload[22:0]);
                mismatches++;
            end
            if (payload[39:23] != want.ram_address) begin
                $error("ram_address: expected 0x%05h, got 0x%05h",
                       want.ram_address, payload[39:23]);
                mismatches++;
            end
            if (payload[47:40] != want.ram_data) begin
                $error("ram_data: expected 0x%02h, got 0x%02h",
                       want.ram_data, payload[47:40]);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// File: sim/tb_top.sv
// ============================================================================
// Cartridge bank controller testbench
// Drives bus accesses through several cartridge settings and checks the
// mapping of every access against a tracked copy of the bank registers.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import cbc_pkg::*;
    import cbc_tb_pkg::*;

    // The watchdog limit sits far above the slowest legal run.
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned RANDOM_ACCESSES = 1700;
    localparam int unsigned PHASES          = 8;
    // The block has two register stages; the settle time covers them.
    localparam int unsigned SETTLE_CYCLES   = 6;

    // Receiver behaviors that rotate through the run.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_LONG_STALLS
    } ready_style_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    bank_map_checker tracker;
    int unsigned     cycle_count = 0;
    int unsigned     burst_left  = 0;
    int unsigned     settings_used = 0;
    ready_style_t    ready_style = READY_ALWAYS;
    int unsigned     style_left  = 0;

    cartridge_bank_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver. Each style holds for a random stretch so that stalls land on
    // every phase of the pipeline, and the always-ready style gives
    // stretches with no back pressure at all.
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            ready_style <= ready_style_t'($urandom_range(0, 3));
            style_left  <= $urandom_range(20, 300);
        end
        else
        begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_tready <= ((cycle_count % 9) < 4);
            default:        m_tready <= ($urandom_range(0, 7) == 0) ? ~m_tready : m_tready;
        endcase
    end

    // Every result taken from the master stream is checked against the
    // oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_mapping(m_tuser, m_tdata);
    end

    // Presents one access from a falling edge until it is accepted, then
    // decides whether the sender keeps going or takes a gap. The valid
    // line is only lowered for a gap, so back-to-back items keep it high.
    task automatic send_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] wb);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {wb, addr};
        do @(posedge clk); while (!s_tready);
        tracker.note_access(op, addr, wb);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Holds the sender off until every predicted result has come back, then
    // lets the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Configuration only changes with the block idle. The bank registers
    // carry over, so each new setting starts from whatever the last one left.
    task automatic configure(input logic [7:0] cart_type, input logic [23:0] rom_bytes,
                             input logic ram_fitted);
        wait_idle();
        write_register(CFG_MAPPER_CODE, {16'd0, cart_type});
        write_register(CFG_ROM_EXTENT, rom_bytes);
        write_register(CFG_RAM_PRESENT, {23'd0, ram_fitted});
        settings_used++;
    endtask

    // Random access shaped toward real bus traffic: mostly ROM reads, bank
    // register writes and RAM window accesses, plus some anywhere on the bus.
    task automatic random_access();
        int unsigned pick;
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wb;
        pick = $urandom_range(0, 99);
        wb   = 8'($urandom_range(0, 255));
        if (pick < 35)
        begin
            op   = OP_READ;
            addr = 16'($urandom_range(0, 32'h7FFF));
        end
        else if (pick < 60)
        begin
            op   = OP_WRITE;
            addr = 16'($urandom_range(0, 32'h7FFF));
            // Mostly unlock RAM so the RAM window stays reachable.
            if (addr < BANK_SELECT_BASE && $urandom_range(0, 3) != 0)
                wb[3:0] = RAM_ENABLE_KEY;
        end
        else if (pick < 85)
        begin
            op   = 1'($urandom_range(0, 1));
            addr = 16'($urandom_range(32'hA000, 32'hBFFF));
        end
        else
        begin
            op   = 1'($urandom_range(0, 1));
            addr = 16'($urandom_range(0, 32'hFFFF));
        end
        send_access(op, addr, wb);
    endtask

    initial
    begin
        int unsigned kind;
        logic [7:0]  cart_type;
        logic [23:0] rom_bytes;

        tracker = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: first mapper kind, 32 KiB of ROM, no RAM.
        send_access(OP_READ,  16'h0000, 8'h00);
        send_access(OP_WRITE, 16'h2000, 8'h00);   // bank 0 is promoted to bank 1
        send_access(OP_READ,  16'h7FFF, 8'hFF);
        send_access(OP_WRITE, 16'h3FFF, 8'h02);
        send_access(OP_READ,  16'h4000, 8'h00);   // bank 2 is past the ROM end
        send_access(OP_WRITE, 16'h0000, 8'h0A);
        send_access(OP_READ,  16'hA000, 8'h00);   // RAM enabled but not fitted
        send_access(OP_WRITE, 16'hBFFF, 8'h55);   // dropped for the same reason
        send_access(OP_READ,  16'h8000, 8'h00);   // video space
        send_access(OP_WRITE, 16'hFFFF, 8'hFF);

        // Banked first kind with the largest ROM and RAM fitted.
        configure(8'h03, 24'h800000, 1'b1);
        send_access(OP_WRITE, 16'h4000, 8'hFF);
        send_access(OP_READ,  16'hBFFF, 8'h00);   // simple mode pins RAM bank 0
        send_access(OP_WRITE, 16'h7FFF, 8'h01);   // advanced mode
        send_access(OP_READ,  16'h0000, 8'h00);   // low window follows upper bank
        send_access(OP_READ,  16'h7FFF, 8'h00);
        send_access(OP_WRITE, 16'hA123, 8'hA5);

        // Third kind with no ROM and no RAM: clock registers still read 0x00.
        configure(8'h13, 24'h000000, 1'b0);
        send_access(OP_READ,  16'h0000, 8'h00);
        send_access(OP_WRITE, 16'h5FFF, 8'h08);
        send_access(OP_READ,  16'hB000, 8'h00);
        send_access(OP_WRITE, 16'h2000, 8'h80);

        // Fifth kind: ninth bank bit, a low bank of 0 that is not promoted, and a
        // RAM bank left at 8 by the previous kind.
        configure(8'h19, 24'hFFFFFF, 1'b1);
        send_access(OP_WRITE, 16'h3000, 8'h01);
        send_access(OP_WRITE, 16'h2FFF, 8'hFF);
        send_access(OP_READ,  16'h7FFF, 8'h00);   // top byte of the ROM space
        send_access(OP_WRITE, 16'h2000, 8'h00);
        send_access(OP_READ,  16'h4000, 8'h00);
        send_access(OP_WRITE, 16'hA000, 8'h3C);

        // Random phases. The first four pin the extremes of the settings,
        // the rest draw a mapper kind and a ROM size at random.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure(8'h01, 24'h800000, 1'b1);
                1: configure(8'h11, 24'h200000, 1'b1);
                2: configure(8'h1E, 24'hFFFFFF, 1'b1);
                3: configure(8'hFF, 24'h000000, 1'b0);
                default:
                begin
                    kind = $urandom_range(0, 3);
                    case (kind)
                        0: cart_type = 8'($urandom_range(0, 32'(MBC1_LAST)));
                        1: cart_type = 8'($urandom_range(32'(MBC3_FIRST), 32'(MBC3_LAST)));
                        2: cart_type = 8'($urandom_range(32'(MBC5_FIRST), 32'(MBC5_LAST)));
                        default: cart_type = 8'($urandom_range(0, 255));
                    endcase
                    if ($urandom_range(0, 2) != 0)
                        rom_bytes = 24'(32'h8000 << $urandom_range(0, 8));
                    else
                        rom_bytes = 24'($urandom_range(0, 32'hFFFFFF));
                    configure(cart_type, rom_bytes, 1'($urandom_range(0, 1)));
                end
            endcase
            for (int i = 0; i < RANDOM_ACCESSES / PHASES; i++)
            begin
                // Halfway through each phase the sender drains the block.
                if (i == RANDOM_ACCESSES / PHASES / 2)
                    wait_idle();
                random_access();
            end
        end

        wait_idle();
        $display("Mapped %0d accesses over %0d cartridge settings.",
                 tracker.accesses, settings_used + 1);
        $display("Results: %0d none, %0d ROM, %0d RAM rd, %0d RAM wr, %0d FF, %0d 00, %0d reg",
                 tracker.target_hits[TGT_NONE], tracker.target_hits[TGT_ROM_READ],
                 tracker.target_hits[TGT_RAM_READ], tracker.target_hits[TGT_RAM_WRITE],
                 tracker.target_hits[TGT_READ_FF], tracker.target_hits[TGT_READ_00],
                 tracker.target_hits[TGT_REG_WRITE]);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_map.sv
hw/rtl/cartridge_bank_controller.sv
sim/cbc_tb_pkg.sv
sim/tb_top.sv
